// ===== sv/refraction_container_tracker_unit_defines.svh =====
// Assertion macros used by the refraction container tracker top level.
`ifndef REFRACTION_CONTAINER_TRACKER_UNIT_DEFINES_SVH
`define REFRACTION_CONTAINER_TRACKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check an implication on every clock edge outside reset.
`define RCTU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rctu assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define RCTU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
    else $error("rctu assertion failed");
`else
`define RCTU_ASSERT(lbl, prop)
`define RCTU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/rctu_pkg.sv =====
// Package with shared constants and controller/datapath types of the tracker.
`timescale 1ns / 1ps
package rctu_pkg;

  localparam int FIELD_W         = 16;
  localparam int ID_WIDE_W       = 32;
  localparam int MAX_NESTING_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam logic [FIELD_W-1:0] OUTSIDE_RESET = 16'h1000;  // 1.0 in Q4.12

  typedef struct packed {
    logic toggle;    // remove or append the current object
    logic cap_n1;    // hold newest index before the toggle
    logic load_out;  // load the output register
    logic clear;     // empty the list
    logic ovf;       // overflow bit for the output register
  } cmd_t;

  typedef struct packed {
    logic dropped;   // current append would hit a full list
    logic empty;     // list holds no entries
  } stat_t;

endpackage

// ===== sv/rctu_in_if.sv =====
// Input channel interface: one ray intersection per transfer.
`timescale 1ns / 1ps
interface rctu_in_if;
  import rctu_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] object_id;
  logic [FIELD_W-1:0] refr_index;
  logic               is_hit;
  logic               last_item;

  modport source(output valid, object_id, refr_index, is_hit, last_item, input ready);
  modport sink(input valid, object_id, refr_index, is_hit, last_item, output ready);
endinterface

// ===== sv/rctu_out_if.sv =====
// Result channel interface: n1, n2 and overflow of one hit.
`timescale 1ns / 1ps
interface rctu_out_if;
  import rctu_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] n1_out;
  logic [FIELD_W-1:0] n2_out;
  logic               overflow;

  modport source(output valid, n1_out, n2_out, overflow, input ready);
  modport sink(input valid, n1_out, n2_out, overflow, output ready);
endinterface

// ===== sv/rctu_ctrl.sv =====
// Controller state machine of the tracker: ray phase, overflow flag, output valid.
`timescale 1ns / 1ps
module rctu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_is_hit,
  input  logic           in_last_item,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  rctu_pkg::stat_t stat,
  output rctu_pkg::cmd_t  cmd
);
  import rctu_pkg::*;

  localparam logic [1:0] ST_SEEK = 2'd0;  // before the hit
  localparam logic [1:0] ST_FIN  = 2'd1;  // hit toggled, read n2 and emit
  localparam logic [1:0] ST_SKIP = 2'd2;  // after the hit, wait for last item

  logic [1:0] state_r, state_nxt;
  logic       last_pend_r, last_pend_nxt;
  logic       ovf_r, ovf_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_xfer;
  logic       out_free;

  assign in_ready  = (state_r != ST_FIN);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    last_pend_nxt = last_pend_r;
    ovf_nxt       = ovf_r;
    unique case (state_r)
      ST_SEEK: begin
        if (in_xfer) begin
          cmd.toggle = 1'b1;
          ovf_nxt    = ovf_r | stat.dropped;
          if (in_is_hit) begin
            cmd.cap_n1    = 1'b1;
            last_pend_nxt = in_last_item;
            state_nxt     = ST_FIN;
          end else if (in_last_item) begin
            cmd.clear = 1'b1;
            ovf_nxt   = 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.ovf      = ovf_r;
          if (last_pend_r) begin
            cmd.clear = 1'b1;
            ovf_nxt   = 1'b0;
            state_nxt = ST_SEEK;
          end else begin
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_SKIP: begin
        if (in_xfer && in_last_item) begin
          cmd.clear = 1'b1;
          ovf_nxt   = 1'b0;
          state_nxt = ST_SEEK;
        end
      end
      default: begin
        state_nxt = ST_SEEK;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEEK;
      last_pend_r <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pend_r <= last_pend_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/rctu_dp.sv =====
// Datapath of the tracker: container list, compare and compaction, output registers.
`timescale 1ns / 1ps
module rctu_dp #(
  parameter int MAX_NESTING = rctu_pkg::MAX_NESTING_DEF,
  parameter int ID_BITS     = rctu_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rctu_pkg::cmd_t               cmd,
  output rctu_pkg::stat_t              stat,
  input  logic [rctu_pkg::FIELD_W-1:0] in_object_id,
  input  logic [rctu_pkg::FIELD_W-1:0] in_refr_index,
  input  logic                         cfg_we,
  input  logic [rctu_pkg::FIELD_W-1:0] cfg_data,
  output logic [rctu_pkg::FIELD_W-1:0] n1_out,
  output logic [rctu_pkg::FIELD_W-1:0] n2_out,
  output logic                         overflow
);
  import rctu_pkg::*;

  localparam int CNT_W = $clog2(MAX_NESTING + 1);
  localparam int IDX_W = $clog2(MAX_NESTING);

  logic [ID_BITS-1:0] ids_r [MAX_NESTING];
  logic [FIELD_W-1:0] ind_r [MAX_NESTING];
  logic [CNT_W-1:0]   count_r;
  logic [FIELD_W-1:0] outside_r;
  logic [FIELD_W-1:0] n1_hold_r;
  logic [FIELD_W-1:0] out_n1_r;
  logic [FIELD_W-1:0] out_n2_r;
  logic               out_ovf_r;

  logic [ID_WIDE_W-1:0]   id_wide;
  logic [ID_BITS-1:0]     key;
  logic [MAX_NESTING-1:0] match;
  logic [MAX_NESTING-1:0] shift;
  logic                   found;
  logic                   full;
  logic                   push;
  logic [CNT_W-1:0]       cnt_m1;
  logic [FIELD_W-1:0]     newest;

  assign id_wide = ID_WIDE_W'(in_object_id);
  assign key     = id_wide[ID_BITS-1:0];

  // Compare the key against every live entry at once.
  always_comb begin
    for (int k = 0; k < MAX_NESTING; k++) begin
      match[k] = (CNT_W'(k) < count_r) && (ids_r[k] == key);
    end
  end

  // Entries at and above the match move down one place.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int k = 0; k < MAX_NESTING; k++) begin
      seen     = seen | match[k];
      shift[k] = seen;
    end
  end

  assign found = |match;
  assign full  = (count_r == CNT_W'(MAX_NESTING));
  assign push  = !found && !full;

  assign stat.dropped = !found && full;
  assign stat.empty   = (count_r == '0);

  assign cnt_m1 = count_r - CNT_W'(1);
  assign newest = (count_r == '0) ? outside_r : ind_r[cnt_m1[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.toggle) begin
      for (int k = 0; k < MAX_NESTING - 1; k++) begin
        if (shift[k]) begin
          ids_r[k] <= ids_r[k+1];
          ind_r[k] <= ind_r[k+1];
        end
      end
      if (push) begin
        ids_r[count_r[IDX_W-1:0]] <= key;
        ind_r[count_r[IDX_W-1:0]] <= in_refr_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      outside_r <= OUTSIDE_RESET;
    end else begin
      if (cfg_we) begin
        outside_r <= cfg_data;
      end
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.toggle) begin
        if (found) begin
          count_r <= count_r - CNT_W'(1);
        end else if (push) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_n1) begin
      n1_hold_r <= newest;
    end
    if (cmd.load_out) begin
      out_n1_r  <= n1_hold_r;
      out_n2_r  <= newest;
      out_ovf_r <= cmd.ovf;
    end
  end

  assign n1_out   = out_n1_r;
  assign n2_out   = out_n2_r;
  assign overflow = out_ovf_r;

endmodule

// ===== sv/refraction_container_tracker_unit.sv =====
// Refraction container tracker: top level joining controller and datapath.
//
// Feed the sorted intersections of one ray, one transfer each, with the
// last one flagged by last_item. The block keeps an ordered list of the
// objects the ray is inside (up to MAX_NESTING, ids compared on their low
// ID_BITS bits) and toggles each object as it arrives: a present object is
// removed with order kept, an absent one is appended, and an append to a
// full list is dropped and remembered as overflow. On the hit item the
// block sends one result: n1 is the newest entry's index before the
// toggle, n2 the newest after it, outside_index standing in for an empty
// list. Items after the hit do nothing until the last item, which empties
// the list. Non-hit items are accepted back to back. On a hit item the
// seek state compares and compacts the list and captures n1; the finish
// state then reads n2 through the same newest-entry read mux and waits
// while the output register still holds a result not yet transferred.
// Write outside_index (reset 1.0, Q4.12) only while no ray is in flight.
`timescale 1ns / 1ps
`include "refraction_container_tracker_unit_defines.svh"
module refraction_container_tracker_unit #(
  parameter int MAX_NESTING = rctu_pkg::MAX_NESTING_DEF,
  parameter int ID_BITS     = rctu_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rctu_in_if.sink                      in_ch,
  rctu_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [rctu_pkg::FIELD_W-1:0] cfg_data
);
  import rctu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each ray: seek the hit, finish the result, skip to the end.
  rctu_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_is_hit    (in_ch.is_hit),
    .in_last_item (in_ch.last_item),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Hold the list and the result payload.
  rctu_dp #(
    .MAX_NESTING (MAX_NESTING),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_object_id  (in_ch.object_id),
    .in_refr_index (in_ch.refr_index),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .n1_out        (out_ch.n1_out),
    .n2_out        (out_ch.n2_out),
    .overflow      (out_ch.overflow)
  );

  // Never overwrite a result that waits for its transfer.
  `RCTU_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_ch.valid || out_ch.ready))
  // Results are loaded only in the finishing cycle, when input is held off.
  `RCTU_ASSERT(a_load_blocks_input, cmd.load_out |-> !in_ch.ready)
  // A clear leaves the list empty.
  `RCTU_ASSERT_NEXT(a_clear_empties, cmd.clear, stat.empty)
  // A captured n1 is always followed by a load before the next item.
  `RCTU_ASSERT_NEXT(a_hit_blocks_input, cmd.cap_n1, !in_ch.ready || cmd.load_out)

endmodule

// ===== verif/refraction_container_tracker_unit_checker.sv =====
// Checker for the refraction container tracker: predicts n1/n2/overflow and compares.
`timescale 1ns / 1ps
module refraction_container_tracker_unit_checker
  import rctu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FIELD_W-1:0] in_object_id,
  input  logic [FIELD_W-1:0] in_refr_index,
  input  logic               in_is_hit,
  input  logic               in_last_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [FIELD_W-1:0] out_n1,
  input  logic [FIELD_W-1:0] out_n2,
  input  logic               out_overflow,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 results_checked,
  output int                 overflow_results
);

  localparam int DEPTH = MAX_NESTING_DEF;
  localparam int IDW   = ID_BITS_DEF;

  typedef struct packed {
    logic [FIELD_W-1:0] n1;
    logic [FIELD_W-1:0] n2;
    logic               overflow;
  } media_t;

  // Predicted container list, newest entry at the top of the count.
  logic [FIELD_W-1:0] outside_idx;
  logic [IDW-1:0]     inside_ids [DEPTH];
  logic [FIELD_W-1:0] inside_idx [DEPTH];
  int                 inside_count;
  logic               hit_reported;
  logic               push_dropped;
  media_t             expected_media[$];
  media_t             oldest_media;

  function automatic logic [FIELD_W-1:0] innermost_index();
    return (inside_count == 0) ? outside_idx : inside_idx[inside_count-1];
  endfunction

  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
    $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // Toggle one object in the list and queue the media pair on the hit.
  task automatic apply_intersection(input logic [FIELD_W-1:0] oid,
                                    input logic [FIELD_W-1:0] rix,
                                    input logic hit, input logic last);
    int                 found;
    int                 k;
    logic [FIELD_W-1:0] n1;
    media_t             m;
    found = -1;
    if (!hit_reported) begin
      n1 = innermost_index();
      for (k = 0; k < inside_count; k++) begin
        if (found < 0 && inside_ids[k] == oid[IDW-1:0]) found = k;
      end
      if (found >= 0) begin
        for (k = found; k < inside_count - 1; k++) begin
          inside_ids[k] = inside_ids[k+1];
          inside_idx[k] = inside_idx[k+1];
        end
        inside_count--;
      end else if (inside_count < DEPTH) begin
        inside_ids[inside_count] = oid[IDW-1:0];
        inside_idx[inside_count] = rix;
        inside_count++;
      end else begin
        push_dropped = 1'b1;
      end
      if (hit) begin
        m.n1       = n1;
        m.n2       = innermost_index();
        m.overflow = push_dropped;
        expected_media.push_back(m);
        hit_reported = 1'b1;
      end
    end
    if (last) begin
      inside_count = 0;
      hit_reported = 1'b0;
      push_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      outside_idx      = OUTSIDE_RESET;
      inside_count     = 0;
      hit_reported     = 1'b0;
      push_dropped     = 1'b0;
      fail_count       = 0;
      results_checked  = 0;
      overflow_results = 0;
      expected_media.delete();
    end else begin
      if (cfg_we) outside_idx = cfg_data;
      if (in_valid && in_ready)
        apply_intersection(in_object_id, in_refr_index, in_is_hit, in_last_item);
      if (out_valid && out_ready) begin
        if (expected_media.size() == 0) begin
          report_mismatch("result with nothing expected, n1", out_n1, '0);
        end else begin
          oldest_media = expected_media.pop_front();
          results_checked++;
          if (oldest_media.overflow) overflow_results++;
          if (out_n1 !== oldest_media.n1) report_mismatch("n1_out", out_n1, oldest_media.n1);
          if (out_n2 !== oldest_media.n2) report_mismatch("n2_out", out_n2, oldest_media.n2);
          if (out_overflow !== oldest_media.overflow)
            report_mismatch("overflow", {15'd0, out_overflow}, {15'd0, oldest_media.overflow});
        end
      end
    end
    pending_count = expected_media.size();
  end

endmodule

// ===== verif/refraction_container_tracker_unit_test.sv =====
// Testbench top: streams ray intersections into the tracker and reports the verdict.
`timescale 1ns / 1ps
module refraction_container_tracker_unit_test;
  import rctu_pkg::*;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_mode_e;
  typedef enum int {RAY_SHUFFLED, RAY_NESTED, RAY_DEEP, RAY_NOISE} ray_kind_e;

  typedef struct packed {
    logic [FIELD_W-1:0] oid;
    logic [FIELD_W-1:0] rix;
    logic               hit;
    logic               last;
  } intersection_t;

  localparam int PHASE_ITEMS      = 265;  // input transfers per random phase
  localparam int PHASES           = 5;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 8;    // margin for trailing items to settle
  localparam int TAIL_CYCLES      = 20;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [FIELD_W-1:0] cfg_data;
  logic               long_hold = 1'b0;
  logic               ray_hit_seen;

  int fail_count;
  int pending_count;
  int results_checked;
  int overflow_results;
  int burst_left;
  int sent_items;
  int counted_items;
  int rays_sent;
  int cfg_writes;

  rctu_in_if  in_ch();
  rctu_out_if out_ch();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  refraction_container_tracker_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  refraction_container_tracker_unit_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_object_id    (in_ch.object_id),
    .in_refr_index   (in_ch.refr_index),
    .in_is_hit       (in_ch.is_hit),
    .in_last_item    (in_ch.last_item),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_n1          (out_ch.n1_out),
    .out_n2          (out_ch.n2_out),
    .out_overflow    (out_ch.overflow),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .overflow_results(overflow_results)
  );

  // Hard stop far beyond the slowest legal run.
  initial begin
    #(64'd5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // Result receiver: switch between stall patterns at random intervals, and
  // honor a long hold-off when the stimulus asks for one. Drive ready at the
  // falling edge only.
  initial begin : receiver
    rx_mode_e mode;
    int       mode_left;
    int       period;
    int       phase;
    out_ch.ready = 1'b0;
    mode         = RX_OPEN;
    mode_left    = 100;
    period       = 3;
    phase        = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        // Hold off so results back up and the block stalls its input.
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(40, 300);
          period    = $urandom_range(2, 6);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN:     out_ch.ready = 1'b1;
          RX_RANDOM:   out_ch.ready = ($urandom_range(0, 99) < 60);
          RX_PERIODIC: out_ch.ready = ((phase % period) != 0);
          default:     out_ch.ready = ($urandom_range(0, 99) < 15);
        endcase
      end
    end
  end

  // Offer one intersection and hold it until the transfer. Open a new burst,
  // possibly after a gap, when the current one is used up.
  task automatic send_intersection(input intersection_t x);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.object_id  = x.oid;
    in_ch.refr_index = x.rix;
    in_ch.is_hit     = x.hit;
    in_ch.last_item  = x.last;
    in_ch.valid      = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    sent_items++;
    // Items after the hit are ignored by the block; count only the others.
    if (!ray_hit_seen || x.last) counted_items++;
    if (x.hit) ray_hit_seen = 1'b1;
    if (x.last) ray_hit_seen = 1'b0;
  endtask

  task automatic send_item(input logic [FIELD_W-1:0] oid, input logic [FIELD_W-1:0] rix,
                           input logic hit, input logic last);
    intersection_t x;
    x = '{oid: oid, rix: rix, hit: hit, last: last};
    send_intersection(x);
  endtask

  // Drop valid and wait until every expected result has been transferred,
  // then let trailing non-hit items settle inside the block.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_outside(input logic [FIELD_W-1:0] value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_writes++;
  endtask

  // Build and send one ray. Well-formed rays enter and leave each object;
  // deep rays overfill the list around the hit; noise rays toggle two ids
  // and random others, with random hit flags.
  task automatic run_ray(input ray_kind_e kind);
    intersection_t      seq[$];
    int                 order[$];
    logic [FIELD_W-1:0] rix_of[32];
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] stride;
    logic [FIELD_W-1:0] id_a;
    logic [FIELD_W-1:0] id_b;
    intersection_t      x;
    int                 objs;
    int                 len;
    int                 hit_at;
    int                 i;
    int                 j;
    int                 tmp;
    if (kind == RAY_NOISE) begin
      len  = $urandom_range(1, 8);
      id_a = FIELD_W'($urandom_range(0, 16'hFFFF));
      id_b = FIELD_W'($urandom_range(0, 16'hFFFF));
      for (i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0:       x.oid = id_a;
          1:       x.oid = id_b;
          default: x.oid = FIELD_W'($urandom_range(0, 16'hFFFF));
        endcase
        x.rix  = FIELD_W'($urandom_range(0, 16'hFFFF));
        x.hit  = ($urandom_range(0, 99) < 25);
        x.last = (i == len - 1);
        seq.push_back(x);
      end
    end else begin
      objs   = (kind == RAY_DEEP) ? $urandom_range(15, 20) : $urandom_range(1, 6);
      base   = FIELD_W'($urandom_range(0, 16'hFFFF));
      stride = FIELD_W'($urandom_range(0, 16'hFFFF)) | 16'h0001;  // odd stride keeps ids distinct
      for (i = 0; i < objs; i++) rix_of[i] = FIELD_W'($urandom_range(0, 16'hFFFF));
      if (kind == RAY_SHUFFLED) begin
        for (i = 0; i < objs; i++) begin
          order.push_back(i);
          order.push_back(i);
        end
        for (i = order.size() - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
      end else begin
        for (i = 0; i < objs; i++) order.push_back(i);
        for (i = objs - 1; i >= 0; i--) order.push_back(i);
      end
      len = order.size();
      if (kind == RAY_DEEP) hit_at = $urandom_range(14, objs);
      else hit_at = ($urandom_range(0, 99) < 90) ? $urandom_range(0, len - 1) : -1;
      // Cut some rays short: the last item then falls mid-list.
      if ($urandom_range(0, 99) < 15) len = $urandom_range(1, len);
      for (i = 0; i < len; i++) begin
        x.oid  = base + FIELD_W'(order[i]) * stride;
        x.rix  = rix_of[order[i]];
        x.hit  = (i == hit_at) ||
                 (hit_at >= 0 && i > hit_at && $urandom_range(0, 99) < 20);
        x.last = (i == len - 1);
        seq.push_back(x);
      end
    end
    foreach (seq[k]) send_intersection(seq[k]);
    rays_sent++;
  endtask

  initial begin : stimulus
    int        ph;
    int        goal;
    int        r;
    int        k;
    ray_kind_e kind;
    logic [FIELD_W-1:0] setting;

    // Known values on every input from time zero.
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.object_id  = '0;
    in_ch.refr_index = '0;
    in_ch.is_hit     = 1'b0;
    in_ch.last_item  = 1'b0;
    ray_hit_seen     = 1'b0;
    burst_left       = 0;
    sent_items       = 0;
    counted_items    = 0;
    rays_sent        = 0;
    cfg_writes       = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rays, outside index at its reset value of 1.0.
    // Hit on the only item, which is also the last: empty list in, one entry out.
    send_item(16'h0000, 16'hFFFF, 1'b1, 1'b1);
    // Append, hit on a second append, a repeated hit, then the last item.
    send_item(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_item(16'h8000, 16'h1234, 1'b1, 1'b0);
    send_item(16'h8000, 16'h4321, 1'b1, 1'b0);
    send_item(16'h0001, 16'h5555, 1'b0, 1'b1);
    // Remove the older entry, below the newest, on the hit.
    send_item(16'h00AA, 16'h1800, 1'b0, 1'b0);
    send_item(16'h0055, 16'h2000, 1'b0, 1'b0);
    send_item(16'h00AA, 16'h1800, 1'b1, 1'b1);
    // A ray without a hit: enter and leave.
    send_item(16'h7FFF, 16'hAAAA, 1'b0, 1'b0);
    send_item(16'h7FFF, 16'hAAAA, 1'b0, 1'b1);
    // Fill the list, then hit on a push to the full list.
    for (k = 0; k < MAX_NESTING_DEF; k++)
      send_item(16'h0100 + FIELD_W'(k), 16'h0123 + FIELD_W'(k) * 16'h0400, 1'b0, 1'b0);
    send_item(16'hF0F0, 16'h3C3C, 1'b1, 1'b1);
    drain_results();

    // Random phases, each under a different outside index; the extremes first.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       setting = 16'hFFFF;
        1:       setting = 16'h0000;
        3:       setting = OUTSIDE_RESET;
        default: setting = FIELD_W'($urandom_range(0, 16'hFFFF));
      endcase
      write_outside(setting);
      // Hold off the receiver while items keep coming in this phase.
      if (ph == 1 || ph == 3) long_hold = 1'b1;
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        r = $urandom_range(0, 99);
        if (r < 45) kind = RAY_SHUFFLED;
        else if (r < 70) kind = RAY_NESTED;
        else if (r < 82) kind = RAY_DEEP;
        else kind = RAY_NOISE;
        run_ray(kind);
        // Now and then let everything drain mid-phase.
        if ($urandom_range(0, 99) < 4) drain_results();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d intersections in %0d rays (%0d not ignored), %0d index writes.",
             sent_items, rays_sent, counted_items, cfg_writes);
    $display("Checked %0d hit results, %0d of them with a dropped push.",
             results_checked, overflow_results);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
